// ----- rtl/mcba_pkg.sv -----
`default_nettype none

package mcba_pkg;

   // Size and offset fields are byte counts of this width.
   localparam int SIZE_BITS = 20;

   // Chunk table depth and the width of the chunk index field.
   localparam int MAX_CHUNKS = 16;
   localparam int IDX_BITS   = 4;

   // Reset value of the default chunk capacity register.
   localparam logic [SIZE_BITS-1:0] DEFAULT_CHUNK_RESET = SIZE_BITS'(1024 * 8);

   // Request commands.
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef struct packed {
      logic                 cmd;
      logic [SIZE_BITS-1:0] size;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]  chunk_index;
      logic [SIZE_BITS-1:0] offset;
      logic                 opened_chunk;
      logic                 failed;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/mcba_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module mcba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/multi_chunk_bump_allocator_unit.sv -----
`default_nettype none

// Arena bump allocator over a table of up to MAX_CHUNKS chunks. An allocate
// request scans the open chunks in the order they were opened, one chunk top
// per cycle out of a RAM with registered read, and takes the first chunk whose
// top is at least the requested size; the top moves down by the size and the
// new top is returned as the offset. If no chunk fits, a new chunk of capacity
// max(default_chunk_bytes, size) is opened, or, with the table full, the
// request fails with the failed flag set. A release request closes all chunks
// at once. One request is worked on at a time: an allocation passes through
// the accept, one scan step per chunk visited, the opening of a chunk when
// none fits, and the loading of the response, which waits until the output
// register is free; a release passes through the accept and the response. The
// default capacity register may be written only while no request is in flight.
module multi_chunk_bump_allocator_unit #(
   parameter int MAX_CHUNKS = mcba_pkg::MAX_CHUNKS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire mcba_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output mcba_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [mcba_pkg::SIZE_BITS-1:0] csr_wr_data
);

   localparam int SB = mcba_pkg::SIZE_BITS;
   localparam int IB = mcba_pkg::IDX_BITS;
   localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int CW = $clog2(MAX_CHUNKS + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_CHUNKS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_OPEN,
      S_ANSWER
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [SB-1:0]     size_ff, size_in;
   logic [SB-1:0]     default_ff, default_in;
   mcba_pkg::rsp_type result_ff, result_in;
   mcba_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [SB-1:0]     ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   logic [SB-1:0]     ram_rd_data;

   logic [CW-1:0]     next_idx;
   logic [SB-1:0]     new_cap;

   // Chunk tops; read data is only used for entries below the open count, so those were written.
   mcba_ram #(
      .WIDTH (SB),
      .DEPTH (MAX_CHUNKS)
   ) u_top_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign next_idx = CW'(idx_ff) + CW'(1);
   assign new_cap  = (size_ff > default_ff) ? size_ff : default_ff;

   // Next-state logic: scan, open, and response hand-off.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      size_in      = size_ff;
      default_in   = csr_wr_en ? csr_wr_data : default_ff;
      result_in    = result_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = ram_rd_data - size_ff;
      ram_rd_addr  = AW'(next_idx);

      case (state_ff)
         S_IDLE: begin
            ram_rd_addr = '0;
            if (req_valid) begin
               size_in = req_data.size;
               idx_in  = '0;
               if (req_data.cmd == mcba_pkg::CMD_RELEASE) begin
                  count_in  = '0;
                  result_in = '0;
                  state_in  = S_ANSWER;
               end else if (count_ff == '0) begin
                  state_in = S_OPEN;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Read data holds the top of chunk idx_ff.
            if (size_ff <= ram_rd_data) begin
               ram_wr_en                = 1'b1;
               result_in.chunk_index    = IB'(idx_ff);
               result_in.offset         = ram_rd_data - size_ff;
               result_in.opened_chunk   = 1'b0;
               result_in.failed         = 1'b0;
               state_in                 = S_ANSWER;
            end else if (next_idx < count_ff) begin
               idx_in = AW'(next_idx);
            end else begin
               state_in = S_OPEN;
            end
         end
         S_OPEN: begin
            if (count_ff == COUNT_FULL) begin
               result_in        = '0;
               result_in.failed = 1'b1;
            end else begin
               ram_wr_en              = 1'b1;
               ram_wr_addr            = AW'(count_ff);
               ram_wr_data            = new_cap - size_ff;
               result_in.chunk_index  = IB'(count_ff);
               result_in.offset       = new_cap - size_ff;
               result_in.opened_chunk = 1'b1;
               result_in.failed       = 1'b0;
               count_in               = count_ff + CW'(1);
            end
            state_in = S_ANSWER;
         end
         S_ANSWER: begin
            // Load the response once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = result_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         default_ff   <= mcba_pkg::DEFAULT_CHUNK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         default_ff   <= default_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff     <= size_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
